// File: rtl/swmm_pkg.sv
// swmm_pkg: shared types and constants for the sliding window mean/median block
// no dependencies; used by the interfaces, the divider and the top level
package swmm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MIN_W    = 5;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic        [MIN_W-1:0]    min_type;

   localparam min_type MIN_RESET = min_type'(1);

endpackage

// File: rtl/swmm_if.sv
// swmm_req_if / swmm_rsp_if: valid/ready channels for samples and results
// depends on swmm_pkg
interface swmm_req_if;
   logic                 valid;
   logic                 ready;
   swmm_pkg::sample_type sample;
   logic                 clear;

   modport source (output valid, sample, clear, input ready);
   modport sink   (input valid, sample, clear, output ready);
endinterface

interface swmm_rsp_if #(parameter int CountW = 5);
   logic                 valid;
   logic                 ready;
   logic [CountW-1:0]    sample_count;
   logic                 stats_valid;
   swmm_pkg::sample_type mean_value;
   swmm_pkg::sample_type median_value;
   logic                 have_samples;
   swmm_pkg::sample_type oldest_value;
   swmm_pkg::sample_type newest_value;

   modport source (output valid, sample_count, stats_valid, mean_value, median_value,
                   have_samples, oldest_value, newest_value, input ready);
   modport sink   (input valid, sample_count, stats_valid, mean_value, median_value,
                   have_samples, oldest_value, newest_value, output ready);
endinterface

// File: rtl/swmm_ram.sv
// swmm_ram: generic single write port, single read port ram with registered read
// no dependencies
module swmm_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/swmm_div.sv
// swmm_div: serial restoring divider, signed wide dividend by small unsigned divisor
// depends on swmm_pkg; one quotient bit per cycle, truncates toward zero
module swmm_div #(
   parameter int SumW   = 36,
   parameter int CountW = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SumW-1:0]     dividend,
   input  logic        [CountW-1:0]   divisor,
   output logic                       done,
   output swmm_pkg::sample_type       quotient
);

   localparam int CntW = $clog2(SumW + 1);

   logic [SumW-1:0]   mag_ff;
   logic [CountW:0]   rem_ff;
   logic [CntW-1:0]   cnt_ff;
   logic              neg_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CountW:0]   trial;
   logic              fits;
   swmm_pkg::sample_type q_low;

   // one restoring step
   assign trial = {rem_ff[CountW-1:0], mag_ff[SumW-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(SumW);
            rem_ff  <= '0;
            neg_ff  <= dividend[SumW-1];
            mag_ff  <= dividend[SumW-1] ? SumW'(-dividend) : SumW'(dividend);
         end else if (busy_ff) begin
            rem_ff <= fits ? (trial - {1'b0, divisor}) : trial;
            mag_ff <= {mag_ff[SumW-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // apply the sign
   assign q_low    = mag_ff[swmm_pkg::SAMPLE_W-1:0];
   assign quotient = neg_ff ? -q_low : q_low;
   assign done     = done_ff;

endmodule

// File: rtl/sliding_window_mean_median.sv
// sliding_window_mean_median: ring of samples with mean, median, oldest and newest
// depends on swmm_pkg, swmm_if, swmm_ram, swmm_div
//
//  channel   dir  handshake          payload
//  req_ch    in   valid/ready        sample, clear
//  rsp_ch    out  valid/ready        sample_count, stats_valid, mean_value,
//                                    median_value, have_samples, oldest/newest
//  csr_*     in   csr_wr_en          csr_wr_data (min_samples)
//
// one transaction at a time; a clear goes straight to the output register, a sample
// reads its oldest entry and, when stats are valid (held samples reach min_samples),
// then runs the rank scan over two ram copies and the serial divider
// reset is synchronous; window empties and min_samples returns to 1
// a result waits in the output register; the next request is taken meanwhile
module sliding_window_mean_median #(
   parameter int WINDOW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   swmm_req_if.sink              req_ch,
   swmm_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  swmm_pkg::min_type     csr_wr_data
);

   localparam int AW   = $clog2(WINDOW);
   localparam int CW   = $clog2(WINDOW + 1);
   localparam int SumW = swmm_pkg::SAMPLE_W + AW;

   typedef enum logic [3:0] {
      S_IDLE, S_OLD, S_OLDW, S_CAND, S_SCAN, S_EVAL, S_DIVGO, S_DIVW, S_OUT
   } state_type;

   state_type            state_ff;
   logic [AW-1:0]        wp_ff;
   logic [CW-1:0]        n_ff;
   swmm_pkg::min_type    min_ff;
   logic [AW-1:0]        i_ff;
   logic [CW-1:0]        j_ff;
   logic                 pv_ff;
   logic [CW-1:0]        less_ff;
   logic [CW-1:0]        eq_ff;
   logic signed [SumW-1:0] sum_ff;
   swmm_pkg::sample_type oldest_ff, newest_ff, lo_ff, hi_ff, mean_ff;

   logic                 rsp_valid_ff;
   logic [CW-1:0]        rsp_count_ff;
   logic                 rsp_stats_ff, rsp_have_ff;
   swmm_pkg::sample_type rsp_mean_ff, rsp_med_ff, rsp_old_ff, rsp_new_ff;

   logic                 accept;
   logic                 wr_en;
   logic [AW-1:0]        rd_addr_a, rd_addr_b;
   swmm_pkg::sample_type rd_a, rd_b;
   logic                 stats_ok;
   logic                 div_start, div_done;
   swmm_pkg::sample_type div_q;
   logic [CW-1:0]        k1, k2, upper;
   logic signed [swmm_pkg::SAMPLE_W:0] pair_sum;
   swmm_pkg::sample_type median;
   logic                 out_free;

   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign wr_en    = accept && !req_ch.clear;
   assign stats_ok = (n_ff != '0) && (32'(n_ff) >= 32'(min_ff));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // read addresses: port a holds the oldest entry or the candidate, port b streams
   always_comb begin
      rd_addr_a = i_ff;
      if (state_ff == S_OLD) begin
         rd_addr_a = (n_ff == CW'(WINDOW)) ? wp_ff : '0;
      end
      rd_addr_b = (state_ff == S_CAND) ? '0 : j_ff[AW-1:0];
   end

   // two copies of the ring, written together
   swmm_ram #(.Width(swmm_pkg::SAMPLE_W), .Depth(WINDOW)) u_ram_a (
      .clock, .wr_en, .wr_addr(wp_ff), .wr_data(req_ch.sample),
      .rd_addr(rd_addr_a), .rd_data(rd_a)
   );
   swmm_ram #(.Width(swmm_pkg::SAMPLE_W), .Depth(WINDOW)) u_ram_b (
      .clock, .wr_en, .wr_addr(wp_ff), .wr_data(req_ch.sample),
      .rd_addr(rd_addr_b), .rd_data(rd_b)
   );

   assign div_start = (state_ff == S_DIVGO);

   swmm_div #(.SumW(SumW), .CountW(CW)) u_div (
      .clock, .reset, .start(div_start), .dividend(sum_ff), .divisor(n_ff),
      .done(div_done), .quotient(div_q)
   );

   // sorted positions of the two middle values and the candidate's span
   assign k1    = (n_ff - 1'b1) >> 1;
   assign k2    = n_ff >> 1;
   assign upper = less_ff + eq_ff;

   // median: mean of the two middle values, truncated toward zero
   assign pair_sum = (swmm_pkg::SAMPLE_W+1)'(lo_ff) + (swmm_pkg::SAMPLE_W+1)'(hi_ff);
   assign median   = swmm_pkg::SAMPLE_W'((pair_sum + pair_sum[swmm_pkg::SAMPLE_W]) >>> 1);

   // sequencer, window state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         n_ff         <= '0;
         min_ff       <= swmm_pkg::MIN_RESET;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_ch.clear) begin
                     wp_ff    <= '0;
                     n_ff     <= '0;
                     state_ff <= S_OUT;
                  end else begin
                     newest_ff <= req_ch.sample;
                     wp_ff     <= (wp_ff == AW'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
                     if (n_ff != CW'(WINDOW)) begin
                        n_ff <= n_ff + 1'b1;
                     end
                     state_ff <= S_OLD;
                  end
               end
            end
            S_OLD: state_ff <= S_OLDW;
            S_OLDW: begin
               oldest_ff <= rd_a;
               i_ff      <= '0;
               sum_ff    <= '0;
               state_ff  <= stats_ok ? S_CAND : S_OUT;
            end
            S_CAND: begin
               j_ff     <= CW'(1);
               pv_ff    <= 1'b1;
               less_ff  <= '0;
               eq_ff    <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (pv_ff) begin
                  if (rd_b < rd_a) begin
                     less_ff <= less_ff + 1'b1;
                  end
                  if (rd_b == rd_a) begin
                     eq_ff <= eq_ff + 1'b1;
                  end
                  if (i_ff == '0) begin
                     sum_ff <= sum_ff + SumW'(rd_b);
                  end
               end
               if (j_ff != n_ff) begin
                  j_ff  <= j_ff + 1'b1;
                  pv_ff <= 1'b1;
               end else begin
                  pv_ff <= 1'b0;
               end
               if (!pv_ff) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (less_ff <= k1 && k1 < upper) begin
                  lo_ff <= rd_a;
               end
               if (less_ff <= k2 && k2 < upper) begin
                  hi_ff <= rd_a;
               end
               i_ff <= i_ff + 1'b1;
               state_ff <= (CW'(i_ff) == n_ff - 1'b1) ? S_DIVGO : S_CAND;
            end
            S_DIVGO: state_ff <= S_DIVW;
            S_DIVW: begin
               if (div_done) begin
                  mean_ff  <= div_q;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= n_ff;
                  rsp_stats_ff <= stats_ok;
                  rsp_have_ff  <= (n_ff != '0);
                  rsp_mean_ff  <= stats_ok ? mean_ff : '0;
                  rsp_med_ff   <= stats_ok ? median : '0;
                  rsp_old_ff   <= (n_ff != '0) ? oldest_ff : '0;
                  rsp_new_ff   <= (n_ff != '0) ? newest_ff : '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sample_count = rsp_count_ff;
   assign rsp_ch.stats_valid  = rsp_stats_ff;
   assign rsp_ch.mean_value   = rsp_mean_ff;
   assign rsp_ch.median_value = rsp_med_ff;
   assign rsp_ch.have_samples = rsp_have_ff;
   assign rsp_ch.oldest_value = rsp_old_ff;
   assign rsp_ch.newest_value = rsp_new_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(WINDOW)) else $error("held count beyond window");

   a_stats_need_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stats_ff |-> rsp_have_ff && rsp_count_ff != '0)
      else $error("stats valid on empty window");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE) else $error("transaction accepted but no work started");

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for sliding_window_mean_median
// depends on swmm_pkg, swmm_if and the block's rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN       = 16;
   localparam int LIMIT     = 4000000;
   localparam int N_RANDOM  = 1830;
   localparam int SETTLE    = 400;

   typedef struct packed {
      logic [4:0] sample_count;
      logic       stats_valid;
      swmm_pkg::sample_type mean_value;
      swmm_pkg::sample_type median_value;
      logic       have_samples;
      swmm_pkg::sample_type oldest_value;
      swmm_pkg::sample_type newest_value;
   } stats_t;

   typedef struct {
      logic       clear;
      swmm_pkg::sample_type sample;
      logic       typed;
      stats_t     want;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   swmm_pkg::min_type csr_wr_data = '0;

   swmm_req_if req_ch ();
   swmm_rsp_if #(.CountW(5)) rsp_ch ();

   sliding_window_mean_median #(.WINDOW(WIN)) DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // window model state
   swmm_pkg::sample_type ring[WIN];
   int unsigned wpos, held;
   int unsigned min_cnt;
   stats_t expected_stats[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;

   function automatic stats_t window_stats(input logic clr, input swmm_pkg::sample_type s);
      stats_t r;
      swmm_pkg::sample_type srt[WIN];
      swmm_pkg::sample_type v;
      longint sum;
      int j;
      if (clr) begin
         wpos = 0;
         held = 0;
      end else begin
         ring[wpos] = s;
         wpos = (wpos + 1) % WIN;
         if (held < WIN) held++;
      end
      r = '0;
      r.sample_count = held[4:0];
      r.have_samples = held != 0;
      r.stats_valid = held != 0 && held >= min_cnt;
      if (r.stats_valid) begin
         sum = 0;
         for (int i = 0; i < held; i++) begin
            sum += longint'(ring[i]);
            v = ring[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
               srt[j] = srt[j-1];
               j--;
            end
            srt[j] = v;
         end
         r.mean_value = swmm_pkg::sample_type'(sum / longint'(held));
         if (held % 2 == 0)
            r.median_value = swmm_pkg::sample_type'(
               (longint'(srt[held/2-1]) + longint'(srt[held/2])) / 2);
         else
            r.median_value = srt[held/2];
      end
      if (held != 0) begin
         r.oldest_value = (held >= WIN) ? ring[wpos] : ring[0];
         r.newest_value = ring[(wpos + WIN - 1) % WIN];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: ready driven at falling edge, transactions checked at rising edge
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      stats_t w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_stats.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            w = expected_stats.pop_front();
            if (rsp_ch.sample_count !== w.sample_count)
               report_mismatch("sample_count", rsp_ch.sample_count, w.sample_count);
            if (rsp_ch.stats_valid !== w.stats_valid)
               report_mismatch("stats_valid", rsp_ch.stats_valid, w.stats_valid);
            if (rsp_ch.mean_value !== w.mean_value)
               report_mismatch("mean_value", rsp_ch.mean_value, w.mean_value);
            if (rsp_ch.median_value !== w.median_value)
               report_mismatch("median_value", rsp_ch.median_value, w.median_value);
            if (rsp_ch.have_samples !== w.have_samples)
               report_mismatch("have_samples", rsp_ch.have_samples, w.have_samples);
            if (rsp_ch.oldest_value !== w.oldest_value)
               report_mismatch("oldest_value", rsp_ch.oldest_value, w.oldest_value);
            if (rsp_ch.newest_value !== w.newest_value)
               report_mismatch("newest_value", rsp_ch.newest_value, w.newest_value);
         end
      end
   end

   // send one transaction, predicting at acceptance
   task automatic send_item(input logic clr, input swmm_pkg::sample_type s,
                            input logic typed, input stats_t want);
      stats_t p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.clear <= clr;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
      p = window_stats(clr, s);
      if (typed && p !== want) report_mismatch("directed table row", p[31:0], want[31:0]);
      expected_stats.push_back(typed ? want : p);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_stats.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_min(input int unsigned v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= swmm_pkg::min_type'(v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      min_cnt = v;
   endtask

   function automatic swmm_pkg::sample_type rand_sample();
      case ($urandom_range(5))
         0: return swmm_pkg::sample_type'(32'h7FFF_FFFF - $urandom_range(3));
         1: return swmm_pkg::sample_type'(32'h8000_0000 + $urandom_range(3));
         2: return swmm_pkg::sample_type'($signed($urandom_range(40)) - 20);
         default: return swmm_pkg::sample_type'($urandom);
      endcase
   endfunction

   row_t directed[$];
   stats_t z;

   initial begin
      int mins[6];
      int phase_idle[4];
      int phase_stall[4];
      req_ch.valid = 1'b0;
      req_ch.clear = 1'b0;
      req_ch.sample = '0;
      wpos = 0;
      held = 0;
      min_cnt = swmm_pkg::MIN_RESET;
      for (int i = 0; i < WIN; i++) ring[i] = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table: extremes, clear on empty, one-sample results typed in
      z = '0;
      directed.push_back('{1'b1, 32'sd0, 1'b1, z});
      z = '{5'd1, 1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
      directed.push_back('{1'b0, 32'sh7FFFFFFF, 1'b1, z});
      directed.push_back('{1'b0, 32'sh7FFFFFFF, 1'b0, z});
      directed.push_back('{1'b0, 32'sh80000000, 1'b0, z});
      directed.push_back('{1'b0, 32'sh80000000, 1'b0, z});
      directed.push_back('{1'b0, -32'sd1, 1'b0, z});
      directed.push_back('{1'b0, 32'sd1, 1'b0, z});
      z = '0;
      directed.push_back('{1'b1, 32'sh5A5A5A5A, 1'b1, z});
      z = '{5'd1, 1'b1, 32'sh80000000, 32'sh80000000, 1'b1, 32'sh80000000, 32'sh80000000};
      directed.push_back('{1'b0, 32'sh80000000, 1'b1, z});
      for (int i = 0; i < 16; i++)
         directed.push_back('{1'b0, swmm_pkg::sample_type'((i % 2) ? -3 * i : 5 * i),
                              1'b0, z});
      foreach (directed[i])
         send_item(directed[i].clear, directed[i].sample, directed[i].typed, directed[i].want);

      // random phases over settings and idling patterns
      mins = '{0, 16, 17, 31, 1, 8};
      phase_idle = '{0, 65, 0, 18};
      phase_stall = '{0, 0, 65, 18};
      for (int ph = 0; ph < 6; ph++) begin
         write_min(mins[ph]);
         send_idle_pct = phase_idle[ph % 4];
         recv_stall_pct = phase_stall[ph % 4];
         for (int n = 0; n < N_RANDOM / 6; n++) begin
            if ($urandom_range(19) == 0)
               send_item(1'b1, swmm_pkg::sample_type'($urandom), 1'b0, z);
            else
               send_item(1'b0, rand_sample(), 1'b0, z);
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_idle();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// File: filelist.f
rtl/swmm_pkg.sv
rtl/swmm_if.sv
rtl/swmm_ram.sv
rtl/swmm_div.sv
rtl/sliding_window_mean_median.sv
tb/sv/tb_top.sv
